[hw/rtl/wsde_pkg.sv]
// Shared types and constants for the WebSocket deframe and echo core.
`timescale 1ns / 1ps
`default_nettype none
package wsde_pkg;

  localparam int LENGTH_BITS = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef logic [LENGTH_BITS-1:0] len_t;
  typedef logic [2:0] kind_t;
  typedef logic [3:0] beats_t;

  typedef enum logic [2:0] {
    PH_HDR0,
    PH_HDR1,
    PH_EXT,
    PH_KEY,
    PH_DATA
  } phase_t;

  localparam kind_t KIND_ECHO       = 3'd0;
  localparam kind_t KIND_PONG_BYTE  = 3'd1;
  localparam kind_t KIND_CLOSE_SEEN = 3'd2;
  localparam kind_t KIND_PONG_SEEN  = 3'd3;
  localparam kind_t KIND_UNSUPP     = 3'd4;

  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;
  localparam logic [3:0] OP_PING  = 4'h9;
  localparam logic [3:0] OP_PONG  = 4'hA;

  localparam logic [7:0] HDR_TEXT  = 8'h81;
  localparam logic [7:0] HDR_PONG  = 8'h8A;
  localparam logic [7:0] LEN_EXT16 = 8'd126;
  localparam logic [7:0] LEN_EXT64 = 8'd127;

  localparam int LEN_SHORT_MAX = 125;
  localparam int LEN_MID_MAX   = 65535;

  localparam logic [3:0] EXT_BYTES16 = 4'd2;
  localparam logic [3:0] EXT_BYTES64 = 4'd8;

  localparam beats_t BEATS_ONE_M1   = 4'd0;
  localparam beats_t BEATS_SHORT_M1 = 4'd1;
  localparam beats_t BEATS_MID_M1   = 4'd3;
  localparam beats_t BEATS_LONG_M1  = 4'd9;

  typedef struct packed {
    logic       is_hdr;
    kind_t      kind;
    beats_t     beats_m1;
    logic       closes;
    logic [7:0] data;
    len_t       len;
  } cmd_t;

endpackage
`default_nettype wire

[hw/rtl/wsde_front.sv]
// Frame header parser and payload unmasker; emits commands into the reply queue.
`timescale 1ns / 1ps
`default_nettype none
module wsde_front
  import wsde_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] rx_byte,
  input  wire logic       chunk_start,
  output logic            push,
  output cmd_t            cmd
);

  phase_t      phase, phase_next;
  logic [3:0]  opcode, opcode_next;
  logic        masked, masked_next;
  logic [3:0]  ext_cnt, ext_cnt_next;
  len_t        plen, plen_next;
  len_t        left, left_next;
  logic [31:0] key, key_next;
  logic [1:0]  midx, midx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase   <= PH_HDR0;
      opcode  <= '0;
      masked  <= 1'b0;
      ext_cnt <= '0;
      plen    <= '0;
      left    <= '0;
      key     <= '0;
      midx    <= '0;
    end else begin
      phase   <= phase_next;
      opcode  <= opcode_next;
      masked  <= masked_next;
      ext_cnt <= ext_cnt_next;
      plen    <= plen_next;
      left    <= left_next;
      key     <= key_next;
      midx    <= midx_next;
    end
  end

  always_comb begin
    phase_t      ph;
    logic [3:0]  cnt_eff;
    logic [3:0]  cnt_dec;
    logic [1:0]  idx_eff;
    logic [1:0]  idx_inc;
    logic        hd;
    len_t        hd_len;
    len_t        left_dec;
    logic [7:0]  kbyte;
    logic        last0;

    phase_next   = phase;
    opcode_next  = opcode;
    masked_next  = masked;
    ext_cnt_next = ext_cnt;
    plen_next    = plen;
    left_next    = left;
    key_next     = key;
    midx_next    = midx;
    push         = 1'b0;
    cmd          = '0;
    hd           = 1'b0;
    hd_len       = plen;
    ph           = phase;
    cnt_eff      = ext_cnt;
    idx_eff      = midx;
    cnt_dec      = '0;
    idx_inc      = '0;
    left_dec     = left;
    kbyte        = '0;
    last0        = 1'b0;

    if (fire) begin
      if (chunk_start) begin
        ph      = PH_HDR0;
        cnt_eff = '0;
        idx_eff = '0;
      end
      ext_cnt_next = cnt_eff;
      midx_next    = idx_eff;
      idx_inc      = idx_eff + 2'd1;

      unique case (ph)
        PH_HDR0: begin
          opcode_next = rx_byte[3:0];
          phase_next  = PH_HDR1;
        end
        PH_HDR1: begin
          masked_next = rx_byte[7];
          midx_next   = '0;
          key_next    = '0;
          if (rx_byte[6:0] == LEN_EXT16[6:0] || rx_byte[6:0] == LEN_EXT64[6:0]) begin
            plen_next    = '0;
            ext_cnt_next = (rx_byte[6:0] == LEN_EXT16[6:0]) ? EXT_BYTES16 : EXT_BYTES64;
            phase_next   = PH_EXT;
          end else begin
            plen_next    = len_t'(rx_byte[6:0]);
            ext_cnt_next = '0;
            hd_len       = len_t'(rx_byte[6:0]);
            if (rx_byte[7]) begin
              phase_next = PH_KEY;
            end else begin
              hd = 1'b1;
            end
          end
        end
        PH_EXT: begin
          plen_next    = {plen[LENGTH_BITS-9:0], rx_byte};
          hd_len       = plen_next;
          cnt_dec      = (cnt_eff != '0) ? cnt_eff - 4'd1 : cnt_eff;
          ext_cnt_next = cnt_dec;
          if (cnt_dec == '0) begin
            if (masked) begin
              phase_next = PH_KEY;
            end else begin
              hd = 1'b1;
            end
          end else begin
            phase_next = PH_EXT;
          end
        end
        PH_KEY: begin
          key_next   = {key[23:0], rx_byte};
          midx_next  = idx_inc;
          phase_next = PH_KEY;
          if (idx_inc == '0) begin
            hd = 1'b1;
          end
        end
        PH_DATA: begin
          kbyte      = masked ? key[{~idx_eff, 3'b000} +: 8] : 8'h00;
          midx_next  = idx_inc;
          left_dec   = (left != '0) ? left - len_t'(1) : left;
          left_next  = left_dec;
          phase_next = PH_DATA;
          if (opcode == OP_TEXT || opcode == OP_PING) begin
            push         = 1'b1;
            cmd.is_hdr   = 1'b0;
            cmd.kind     = (opcode == OP_TEXT) ? KIND_ECHO : KIND_PONG_BYTE;
            cmd.beats_m1 = BEATS_ONE_M1;
            cmd.closes   = (left_dec == '0);
            cmd.data     = rx_byte ^ kbyte;
          end
          if (left_dec == '0) begin
            phase_next = PH_HDR0;
            midx_next  = '0;
          end
        end
        default: begin
          phase_next = PH_HDR0;
        end
      endcase

      if (hd) begin
        last0      = (hd_len == '0);
        left_next  = hd_len;
        midx_next  = '0;
        phase_next = last0 ? PH_HDR0 : PH_DATA;
        push       = 1'b1;
        cmd.is_hdr = 1'b1;
        cmd.len    = hd_len;
        cmd.data   = 8'h00;
        if (opcode == OP_TEXT) begin
          cmd.kind   = KIND_ECHO;
          cmd.closes = last0;
          if (hd_len <= len_t'(LEN_SHORT_MAX)) begin
            cmd.beats_m1 = BEATS_SHORT_M1;
          end else if (hd_len <= len_t'(LEN_MID_MAX)) begin
            cmd.beats_m1 = BEATS_MID_M1;
          end else begin
            cmd.beats_m1 = BEATS_LONG_M1;
          end
        end else if (opcode == OP_PING) begin
          cmd.kind     = KIND_PONG_BYTE;
          cmd.closes   = last0;
          cmd.beats_m1 = BEATS_SHORT_M1;
        end else begin
          cmd.closes   = 1'b0;
          cmd.beats_m1 = BEATS_ONE_M1;
          if (opcode == OP_CLOSE) begin
            cmd.kind = KIND_CLOSE_SEEN;
          end else if (opcode == OP_PONG) begin
            cmd.kind = KIND_PONG_SEEN;
          end else begin
            cmd.kind = KIND_UNSUPP;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/wsde_queue.sv]
// Short command queue between the parser and the reply expander.
`timescale 1ns / 1ps
`default_nettype none
module wsde_queue
  import wsde_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output logic      full,
  output logic      head_valid,
  output cmd_t      head_cmd
);

  cmd_t                   mem [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_CNT_W-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  assign full       = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = mem[rd_ptr];

endmodule
`default_nettype wire

[hw/rtl/wsde_back.sv]
// Reply expander: turns queued commands into output beats.
`timescale 1ns / 1ps
`default_nettype none
module wsde_back
  import wsde_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  head_valid,
  input  wire cmd_t  head_cmd,
  input  wire logic  out_ready,
  output logic       pop,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic [2:0] out_kind,
  output logic       reply_end,
  output logic       last_of_run
);

  beats_t idx;
  logic   beat_last;
  logic   fire;
  logic [63:0] len64;
  beats_t      rem;

  assign out_valid = head_valid;
  assign fire      = out_valid && out_ready;
  assign beat_last = (idx == head_cmd.beats_m1);
  assign pop       = fire && beat_last;
  assign len64     = 64'(head_cmd.len);
  assign rem       = head_cmd.beats_m1 - idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (fire) begin
      idx <= beat_last ? '0 : idx + 4'd1;
    end
  end

  always_comb begin
    out_kind    = head_cmd.kind;
    reply_end   = head_cmd.closes && beat_last;
    last_of_run = beat_last;
    out_byte    = head_cmd.data;
    if (head_cmd.is_hdr) begin
      if (head_cmd.kind == KIND_ECHO) begin
        if (idx == 4'd0) begin
          out_byte = HDR_TEXT;
        end else if (idx == 4'd1) begin
          if (head_cmd.beats_m1 == BEATS_SHORT_M1) begin
            out_byte = len64[7:0];
          end else if (head_cmd.beats_m1 == BEATS_MID_M1) begin
            out_byte = LEN_EXT16;
          end else begin
            out_byte = LEN_EXT64;
          end
        end else begin
          out_byte = len64[{rem[2:0], 3'b000} +: 8];
        end
      end else if (head_cmd.kind == KIND_PONG_BYTE) begin
        out_byte = (idx == 4'd0) ? HDR_PONG : len64[7:0];
      end
    end
  end

endmodule
`default_nettype wire

[hw/rtl/websocket_frame_deframe_echo_core.sv]
// Top level of the WebSocket deframe and echo core.
//
//  channel  signals                                      role
//  in       in_valid/in_ready, rx_byte, chunk_start      received frame bytes
//  out      out_valid/out_ready, out_byte, out_kind,     reply bytes and events
//           reply_end, last_of_run
//
// One byte is taken per cycle while the four-entry command queue has room.
// A byte that completes a header queues a 1 to 10 beat reply, a text or ping
// payload byte one beat; the expander sends one beat per cycle while out_ready
// is high, from the queue head. Input stalls when the queue fills, behind a
// stalled output or when payload bytes pile up behind a long reply header.
// Reset is synchronous and returns the parser to header byte 0, queue empty.
`timescale 1ns / 1ps
`default_nettype none
module websocket_frame_deframe_echo_core
  import wsde_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       chunk_start,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic [2:0]      out_kind,
  output logic            reply_end,
  output logic            last_of_run
);

  logic in_fire;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic full;
  logic head_valid;
  cmd_t head_cmd;

  assign in_ready = !full;
  assign in_fire  = in_valid && in_ready;

  wsde_front u_front (
    .clk         (clk),
    .rst         (rst),
    .fire        (in_fire),
    .rx_byte     (rx_byte),
    .chunk_start (chunk_start),
    .push        (push),
    .cmd         (push_cmd)
  );

  wsde_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  wsde_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_cmd    (head_cmd),
    .out_ready   (out_ready),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_byte    (out_byte),
    .out_kind    (out_kind),
    .reply_end   (reply_end),
    .last_of_run (last_of_run)
  );

endmodule
`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the WebSocket deframe and echo core.
`timescale 1ns / 1ps
module testbench;
  import wsde_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 64;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       reply_end;
    logic       last_of_run;
  } reply_t;

  class frame_echo_model;
    phase_t      phase;
    logic [3:0]  opcode;
    logic        masked;
    logic [3:0]  ext_left;
    len_t        length;
    len_t        remaining;
    logic [31:0] key;
    logic [1:0]  key_pos;
    reply_t      replies[$];
    int          failures;

    function new();
      phase     = PH_HDR0;
      opcode    = '0;
      masked    = 1'b0;
      ext_left  = '0;
      length    = '0;
      remaining = '0;
      key       = '0;
      key_pos   = '0;
      failures  = 0;
    endfunction

    function void push_reply(logic [7:0] data, kind_t kind, logic fin);
      reply_t r;
      r.data        = data;
      r.kind        = kind;
      r.reply_end   = fin;
      r.last_of_run = 1'b0;
      replies.insert(replies.size(), r);
    endfunction

    function void finish_header();
      logic zero;
      int i;
      zero      = (length == 0);
      remaining = length;
      key_pos   = '0;
      case (opcode)
        OP_TEXT: begin
          push_reply(HDR_TEXT, KIND_ECHO, 1'b0);
          if (length <= LEN_SHORT_MAX) begin
            push_reply(length[7:0], KIND_ECHO, zero);
          end else if (length <= LEN_MID_MAX) begin
            push_reply(LEN_EXT16, KIND_ECHO, 1'b0);
            push_reply(length[15:8], KIND_ECHO, 1'b0);
            push_reply(length[7:0], KIND_ECHO, zero);
          end else begin
            push_reply(LEN_EXT64, KIND_ECHO, 1'b0);
            for (i = 7; i >= 0; i--)
              push_reply(length[8*i +: 8], KIND_ECHO, (i == 0) && zero);
          end
        end
        OP_PING: begin
          push_reply(HDR_PONG, KIND_PONG_BYTE, 1'b0);
          push_reply(length[7:0], KIND_PONG_BYTE, zero);
        end
        OP_CLOSE: push_reply(8'h00, KIND_CLOSE_SEEN, 1'b0);
        OP_PONG:  push_reply(8'h00, KIND_PONG_SEEN, 1'b0);
        default:  push_reply(8'h00, KIND_UNSUPP, 1'b0);
      endcase
      phase = zero ? PH_HDR0 : PH_DATA;
    endfunction

    function void take_byte(logic [7:0] b, logic restart);
      int first;
      logic [7:0] v;
      first = replies.size();
      if (restart) begin
        phase    = PH_HDR0;
        ext_left = '0;
        key_pos  = '0;
      end
      case (phase)
        PH_HDR0: begin
          opcode = b[3:0];
          phase  = PH_HDR1;
        end
        PH_HDR1: begin
          masked  = b[7];
          key_pos = '0;
          key     = '0;
          if (b[6:0] == LEN_EXT16[6:0] || b[6:0] == LEN_EXT64[6:0]) begin
            length   = '0;
            ext_left = (b[6:0] == LEN_EXT16[6:0]) ? EXT_BYTES16 : EXT_BYTES64;
            phase    = PH_EXT;
          end else begin
            length   = len_t'(b[6:0]);
            ext_left = '0;
            if (masked) phase = PH_KEY;
            else finish_header();
          end
        end
        PH_EXT: begin
          length = (length << 8) | len_t'(b);
          if (ext_left != 0) ext_left = ext_left - 4'd1;
          if (ext_left == 0) begin
            if (masked) phase = PH_KEY;
            else finish_header();
          end
        end
        PH_KEY: begin
          key     = {key[23:0], b};
          key_pos = key_pos + 2'd1;
          if (key_pos == 0) finish_header();
        end
        default: begin
          v = b;
          if (masked) v = v ^ key[8*(3 - key_pos) +: 8];
          key_pos = key_pos + 2'd1;
          if (remaining != 0) remaining = remaining - 1;
          if (opcode == OP_TEXT) push_reply(v, KIND_ECHO, remaining == 0);
          else if (opcode == OP_PING) push_reply(v, KIND_PONG_BYTE, remaining == 0);
          if (remaining == 0) begin
            phase   = PH_HDR0;
            key_pos = '0;
          end
        end
      endcase
      if (replies.size() > first) replies[replies.size()-1].last_of_run = 1'b1;
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected beat: byte %h kind %0d end %b last %b",
                   got.data, got.kind, got.reply_end, got.last_of_run);
        return;
      end
      want = replies.pop_front();
      if (got.data !== want.data || got.kind !== want.kind ||
          got.reply_end !== want.reply_end || got.last_of_run !== want.last_of_run) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected %h/%0d/%b/%b, got %h/%0d/%b/%b",
                   want.data, want.kind, want.reply_end, want.last_of_run,
                   got.data, got.kind, got.reply_end, got.last_of_run);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       chunk_start = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] out_kind;
  logic       reply_end;
  logic       last_of_run;

  frame_echo_model model;
  reply_t          beat_seen;
  int              items_sent = 0;
  int              cycle_count = 0;
  int              hold_cycles = 0;
  logic            quiet = 1'b0;
  logic            resync = 1'b0;

  websocket_frame_deframe_echo_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .rx_byte     (rx_byte),
    .chunk_start (chunk_start),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .out_kind    (out_kind),
    .reply_end   (reply_end),
    .last_of_run (last_of_run)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // sample mid-cycle: beats seen here are taken at the next rising edge
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready === 1'b1) model.take_byte(rx_byte, chunk_start);
      if (out_valid === 1'b1 && out_ready) begin
        beat_seen.data        = out_byte;
        beat_seen.kind        = out_kind;
        beat_seen.reply_end   = reply_end;
        beat_seen.last_of_run = last_of_run;
        model.check_reply(beat_seen);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic restart);
    int gap;
    logic taken;
    gap = quiet ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    rx_byte     <= b;
    chunk_start <= restart;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (in_ready === 1'b1);
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    resync = 1'b1;
  endtask

  task automatic send_frame();
    logic [3:0]  op;
    logic        masked;
    len_t        len;
    logic [6:0]  code7;
    logic [31:0] mask;
    logic [7:0]  fb[$];
    logic        cut;
    logic        lead;
    int          ext_n;
    int          body;
    int          keep;
    int          pick;
    int          i;
    pick = $urandom_range(0, 99);
    if (pick < 40) op = OP_TEXT;
    else if (pick < 65) op = OP_PING;
    else if (pick < 75) op = OP_CLOSE;
    else if (pick < 85) op = OP_PONG;
    else begin
      op = 4'($urandom_range(0, 15));
      while (op == OP_TEXT || op == OP_PING || op == OP_CLOSE || op == OP_PONG)
        op = 4'($urandom_range(0, 15));
    end
    masked = ($urandom_range(0, 9) < 6);
    pick = $urandom_range(0, 99);
    ext_n = 0;
    if (pick < 70) len = len_t'($urandom_range(0, 12));
    else if (pick < 80) len = len_t'($urandom_range(13, LEN_SHORT_MAX));
    else if (pick < 92) begin
      ext_n = 2;
      len = ($urandom_range(0, 3) == 0) ? len_t'(LEN_MID_MAX) : len_t'($urandom_range(0, 400));
    end else begin
      ext_n = 8;
      case ($urandom_range(0, 2))
        0:       len = '1;
        1:       len = len_t'({$urandom, $urandom});
        default: len = len_t'($urandom_range(0, 300));
      endcase
    end
    if (ext_n == 2) code7 = LEN_EXT16[6:0];
    else if (ext_n == 8) code7 = LEN_EXT64[6:0];
    else code7 = len[6:0];
    fb.insert(fb.size(), {4'($urandom_range(0, 15)), op});
    fb.insert(fb.size(), {masked, code7});
    for (i = ext_n - 1; i >= 0; i--) fb.insert(fb.size(), len[8*i +: 8]);
    mask = $urandom;
    if (masked)
      for (i = 3; i >= 0; i--) fb.insert(fb.size(), mask[8*i +: 8]);
    body = (len <= 40) ? int'(len) : $urandom_range(0, 20);
    repeat (body) fb.insert(fb.size(), 8'($urandom));
    cut  = (len > 40);
    keep = fb.size();
    if ($urandom_range(0, 11) == 0) begin
      keep = $urandom_range(1, fb.size() - 1);
      cut  = 1'b1;
    end
    lead = resync || ($urandom_range(0, 15) == 0);
    for (i = 0; i < keep; i++) send_byte(fb[i], (i == 0) && lead);
    resync = cut;
  endtask

  task automatic send_directed();
    int i;
    send_byte(HDR_TEXT, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte({4'h8, OP_PING}, 1'b0);
    send_byte({1'b1, 7'd1}, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte({4'h8, OP_CLOSE}, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte({4'h0, OP_PONG}, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte({4'h0, OP_TEXT}, 1'b0);
    send_byte(LEN_EXT64, 1'b0);
    for (i = 0; i < 8; i++) send_byte(8'hFF, 1'b0);
    send_byte({4'h8, OP_PING}, 1'b1);
    send_byte(LEN_EXT16, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h2C, 1'b0);
    resync = 1'b1;
  endtask

  initial begin
    int gap;
    logic taken;
    while (rst) @(posedge clk);
    forever begin
      gap = quiet ? 0 : $urandom_range(0, 7);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      taken = 1'b0;
      while (!taken) begin
        @(negedge clk);
        taken = (out_valid === 1'b1);
        @(posedge clk);
      end
    end
  end

  initial begin
    int   directed_items;
    logic hold_done;
    model = new();
    hold_done = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_directed();
    directed_items = items_sent;
    while (items_sent < directed_items + RANDOM_ITEMS) begin
      if (!hold_done && items_sent >= directed_items + 150) begin
        hold_cycles = HOLD_CYCLES;
        hold_done   = 1'b1;
      end
      quiet = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 9) == 0) send_noise();
      else send_frame();
    end
    in_valid <= 1'b0;
    while (model.replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (model.failures == 0 && model.replies.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
